// File: src/ventilation_trend_controller_defines.svh
// assertion macros used by the checker file of ventilation_trend_controller
// depends on: nothing; users provide clk_i and rst_ni in scope
`ifndef VENTILATION_TREND_CONTROLLER_DEFINES_SVH
`define VENTILATION_TREND_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define VTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/vtc_pkg.sv
// types and constants of the ventilation trend controller
// depends on: nothing
`default_nettype none

package vtc_pkg;

  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned MARGIN_W = 10;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CNT_DEPTH = 1 << CNT_W;
  localparam int unsigned PULSE_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TREND_MARGIN = 2'd2;

  // register reset values
  localparam logic [LEVEL_W-1:0]  HIGH_LIMIT_RST   = 16'd800;
  localparam logic [LEVEL_W-1:0]  LOW_LIMIT_RST    = 16'd650;
  localparam logic [MARGIN_W-1:0] TREND_MARGIN_RST = 10'd10;

  typedef enum logic [1:0] {
    MODE_SETTLING = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_HIGH     = 2'd2
  } mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  high_limit;
    logic [LEVEL_W-1:0]  low_limit;
    logic [MARGIN_W-1:0] trend_margin;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic [LEVEL_W-1:0] reference;
    logic [CNT_W-1:0]   counter;
  } state_t;

endpackage

`default_nettype wire

// File: src/vtc_cfg.sv
// configuration registers: high limit, low limit, trend margin
// depends on: vtc_pkg
`default_nettype none

module vtc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vtc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output vtc_pkg::cfg_t                     cfg_o
);
  import vtc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_limit   <= HIGH_LIMIT_RST;
      cfg_q.low_limit    <= LOW_LIMIT_RST;
      cfg_q.trend_margin <= TREND_MARGIN_RST;
    end else if (cfg_we_i) begin
      // writes past the last register are dropped
      unique case (cfg_idx_i)
        REG_HIGH_LIMIT:   cfg_q.high_limit   <= cfg_data_i;
        REG_LOW_LIMIT:    cfg_q.low_limit    <= cfg_data_i;
        REG_TREND_MARGIN: cfg_q.trend_margin <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/vtc_step.sv
// next-state logic for one reading: mode, reference, counter and pulse count
// depends on: vtc_pkg
`default_nettype none

module vtc_step #(
  parameter int unsigned SETTLE_PERIOD = 50,
  parameter int unsigned TREND_PERIOD  = 100
) (
  input  vtc_pkg::state_t                 state_i,
  input  vtc_pkg::cfg_t                   cfg_i,
  input  logic [vtc_pkg::LEVEL_W-1:0]     level_i,
  output vtc_pkg::state_t                 state_o,
  output logic [vtc_pkg::PULSE_W-1:0]     pulses_o
);
  import vtc_pkg::*;

  // constant hit tables over all counter values
  logic [CNT_DEPTH-1:0] settle_hit_mask;
  logic [CNT_DEPTH-1:0] trend_hit_mask;

  for (genvar i = 0; i < CNT_DEPTH; i++) begin : g_mask
    assign settle_hit_mask[i] = ((i % SETTLE_PERIOD) == (SETTLE_PERIOD - 1));
    assign trend_hit_mask[i]  = ((i % TREND_PERIOD) == (TREND_PERIOD - 1));
  end

  logic [CNT_W-1:0]         cnt_inc;
  logic                     settle_hit;
  logic                     trend_hit;
  logic signed [LEVEL_W+1:0] slack;   // reference + margin - level
  logic                     above_high;
  logic                     below_low;

  assign cnt_inc    = state_i.counter + 1'b1;
  assign settle_hit = settle_hit_mask[cnt_inc];
  assign trend_hit  = trend_hit_mask[cnt_inc];
  assign slack      = $signed({2'b00, state_i.reference})
                    + $signed({{(LEVEL_W + 2 - MARGIN_W){1'b0}}, cfg_i.trend_margin})
                    - $signed({2'b00, level_i});
  assign above_high = (level_i > cfg_i.high_limit);
  assign below_low  = (level_i < cfg_i.low_limit);

  always_comb begin
    state_o         = state_i;
    state_o.counter = cnt_inc;
    pulses_o        = '0;
    unique case (state_i.mode)
      MODE_SETTLING: begin
        if (settle_hit) begin
          state_o.counter   = '0;
          state_o.reference = level_i;
          if (above_high) begin
            pulses_o     = 2'd1;
            state_o.mode = MODE_HIGH;
          end else begin
            state_o.mode = MODE_NORMAL;
          end
        end
      end
      MODE_NORMAL: begin
        // level stayed below reference plus margin over the period
        if (trend_hit && (slack > 0)) begin
          pulses_o          = pulses_o + 1'b1;
          state_o.reference = level_i;
          state_o.counter   = '0;
        end
        if (above_high) begin
          pulses_o          = pulses_o + 1'b1;
          state_o.reference = level_i;
          state_o.mode      = MODE_HIGH;
        end
      end
      MODE_HIGH: begin
        // level rose past the margin over the period
        if (trend_hit && (slack < 0)) begin
          pulses_o          = pulses_o + 1'b1;
          state_o.reference = level_i;
          state_o.counter   = '0;
        end
        if (below_low) begin
          pulses_o          = pulses_o + 1'b1;
          state_o.reference = cfg_i.low_limit;
          state_o.mode      = MODE_NORMAL;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/ventilation_trend_controller.sv
// top level of the ventilation trend controller: input register, state, result register
// depends on: vtc_pkg, vtc_cfg, vtc_step
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | co2_level_i
//  out     | from block| out_valid_o / out_stall_i| pulse_count_o, mode_now_o, reference_now_o
//  cfg     | to block  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one word per cycle unless out stalls; an accepted word waits in the input register
// mode, reference and counter update in the cycle a word moves to the result register
// a stall on out holds the result and, once the input register is full, stalls in
// reset clears mode, reference, counter and loads the register defaults
`default_nettype none

module ventilation_trend_controller #(
  parameter int unsigned SETTLE_PERIOD = 50,
  parameter int unsigned TREND_PERIOD  = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [vtc_pkg::LEVEL_W-1:0]      co2_level_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [vtc_pkg::PULSE_W-1:0]      pulse_count_o,
  output logic [1:0]                       mode_now_o,
  output logic [vtc_pkg::LEVEL_W-1:0]      reference_now_o,
  input  logic                             cfg_we_i,
  input  logic [vtc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vtc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import vtc_pkg::*;

  cfg_t cfg;

  logic               in_valid_q;
  logic [LEVEL_W-1:0] in_level_q;
  logic               in_accept;
  logic               advance;

  state_t             state_q;
  state_t             state_d;
  logic [PULSE_W-1:0] pulses_d;

  logic               out_valid_q;
  logic [PULSE_W-1:0] pulse_count_q;
  logic [1:0]         mode_now_q;
  logic [LEVEL_W-1:0] reference_now_q;

  vtc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vtc_step #(
    .SETTLE_PERIOD (SETTLE_PERIOD),
    .TREND_PERIOD  (TREND_PERIOD)
  ) u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .level_i  (in_level_q),
    .state_o  (state_d),
    .pulses_o (pulses_d)
  );

  // word moves on when the result register is empty or being taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_SETTLING, reference: '0, counter: '0};
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_level_q <= co2_level_i;
    end
    if (advance) begin
      pulse_count_q   <= pulses_d;
      mode_now_q      <= state_d.mode;
      reference_now_q <= state_d.reference;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pulse_count_o   = pulse_count_q;
  assign mode_now_o      = mode_now_q;
  assign reference_now_o = reference_now_q;

endmodule

`default_nettype wire

// File: src/vtc_checker.sv
// port-level checks for ventilation_trend_controller, bound to the top level
// depends on: ventilation_trend_controller_defines.svh, vtc_pkg
`default_nettype none
`include "ventilation_trend_controller_defines.svh"

module vtc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [vtc_pkg::PULSE_W-1:0]   pulse_count_o,
  input logic [1:0]                    mode_now_o,
  input logic [vtc_pkg::LEVEL_W-1:0]   reference_now_o
);
  import vtc_pkg::*;

  `VTC_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `VTC_ASSERT_NEXT(a_out_word_held, out_valid_o && out_stall_i, $stable(reference_now_o) && $stable(pulse_count_o), "stalled result changed")
  `VTC_ASSERT_NOW(a_pulse_range, out_valid_o, pulse_count_o != 2'd3, "more than two pulses for one word")
  `VTC_ASSERT_NOW(a_mode_code, out_valid_o, mode_now_o != 2'd3, "unused mode code reported")
  `VTC_ASSERT_NOW(a_settle_quiet, out_valid_o && (mode_now_o == MODE_SETTLING), pulse_count_o == 2'd0, "pulse while still settling")

endmodule

bind ventilation_trend_controller vtc_checker u_vtc_checker (.*);

`default_nettype wire

// File: dv/ventilation_trend_controller_tb.sv
`timescale 1ns / 100ps
// testbench of ventilation_trend_controller: a tracker follows the controller state from
// the accepted readings and checks every result word on the output channel
// depends on: vtc_pkg, ventilation_trend_controller

typedef struct {
  logic [vtc_pkg::PULSE_W-1:0] pulse_count;
  vtc_pkg::mode_e              mode_now;
  logic [vtc_pkg::LEVEL_W-1:0] reference_now;
} vent_result_t;

class ventilator_tracker;
  vtc_pkg::mode_e               mode;
  logic [vtc_pkg::LEVEL_W-1:0]  ref_level;
  logic [vtc_pkg::CNT_W-1:0]    reading_count;
  logic [vtc_pkg::LEVEL_W-1:0]  high_limit;
  logic [vtc_pkg::LEVEL_W-1:0]  low_limit;
  logic [vtc_pkg::MARGIN_W-1:0] trend_margin;
  int                           settle_period;
  int                           trend_period;
  vent_result_t                 expected_words[$];
  int                           words_checked;
  int                           mismatches;

  function new(int settle, int trend);
    settle_period = settle;
    trend_period  = trend;
    mode          = vtc_pkg::MODE_SETTLING;
    ref_level     = '0;
    reading_count = '0;
    high_limit    = vtc_pkg::HIGH_LIMIT_RST;
    low_limit     = vtc_pkg::LOW_LIMIT_RST;
    trend_margin  = vtc_pkg::TREND_MARGIN_RST;
    words_checked = 0;
    mismatches    = 0;
  endfunction

  function void write_reg(logic [vtc_pkg::CFG_IDX_W-1:0] idx,
                          logic [vtc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      vtc_pkg::REG_HIGH_LIMIT:   high_limit = data;
      vtc_pkg::REG_LOW_LIMIT:    low_limit = data;
      vtc_pkg::REG_TREND_MARGIN: trend_margin = data[vtc_pkg::MARGIN_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  // one accepted reading: advance the controller and queue the word it produces
  function void note_reading(logic [vtc_pkg::LEVEL_W-1:0] level);
    vent_result_t want;
    int           diff;
    int           neg_margin;
    int           pulses;
    bit           trend_hit;
    pulses        = 0;
    neg_margin    = -int'(trend_margin);
    diff          = int'(ref_level) - int'(level);
    reading_count = reading_count + 1'b1;
    trend_hit     = (int'(reading_count) % trend_period) == trend_period - 1;
    case (mode)
      vtc_pkg::MODE_SETTLING: begin
        if ((int'(reading_count) % settle_period) == settle_period - 1) begin
          reading_count = '0;
          ref_level     = level;
          if (level > high_limit) begin
            pulses++;
            mode = vtc_pkg::MODE_HIGH;
          end else begin
            mode = vtc_pkg::MODE_NORMAL;
          end
        end
      end
      vtc_pkg::MODE_NORMAL: begin
        // level stayed below reference plus margin since the last check
        if (trend_hit && diff > neg_margin) begin
          pulses++;
          ref_level     = level;
          reading_count = '0;
        end
        if (level > high_limit) begin
          pulses++;
          ref_level = level;
          mode      = vtc_pkg::MODE_HIGH;
        end
      end
      vtc_pkg::MODE_HIGH: begin
        // level rising past the margin while ventilating
        if (trend_hit && diff < neg_margin) begin
          pulses++;
          ref_level     = level;
          reading_count = '0;
        end
        if (level < low_limit) begin
          pulses++;
          ref_level = low_limit;
          mode      = vtc_pkg::MODE_NORMAL;
        end
      end
      default: ;
    endcase
    want.pulse_count   = pulses[vtc_pkg::PULSE_W-1:0];
    want.mode_now      = mode;
    want.reference_now = ref_level;
    expected_words.push_back(want);
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("result word %0d: %s got %0d, expected %0d", words_checked, what, got, want);
    mismatches++;
  endtask

  task check_result(logic [vtc_pkg::PULSE_W-1:0] pulses, logic [1:0] mode_bits,
                    logic [vtc_pkg::LEVEL_W-1:0] ref_bits);
    vent_result_t want;
    words_checked++;
    if (expected_words.size() == 0) begin
      report_mismatch("word with no reading pending, pulses", int'(pulses), 0);
    end else begin
      want = expected_words.pop_front();
      if (pulses !== want.pulse_count) begin
        report_mismatch("pulse_count", int'(pulses), int'(want.pulse_count));
      end
      if (mode_bits !== want.mode_now) begin
        report_mismatch("mode_now", int'(mode_bits), int'(want.mode_now));
      end
      if (ref_bits !== want.reference_now) begin
        report_mismatch("reference_now", int'(ref_bits), int'(want.reference_now));
      end
    end
  endtask

  task report_leftover();
    if (expected_words.size() != 0) begin
      report_mismatch("words never produced, count", 0, expected_words.size());
    end
  endtask
endclass

module ventilation_trend_controller_tb;
  import vtc_pkg::*;

  localparam int SETTLE_PERIOD   = 50;
  localparam int TREND_PERIOD    = 100;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [LEVEL_W-1:0]    sensor_level = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [PULSE_W-1:0]    pulse_count_o;
  logic [1:0]            mode_now_o;
  logic [LEVEL_W-1:0]    reference_now_o;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = REG_HIGH_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  logic recv_hold     = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycle_count   = 0;

  ventilator_tracker tracker;

  ventilation_trend_controller #(
    .SETTLE_PERIOD(SETTLE_PERIOD),
    .TREND_PERIOD (TREND_PERIOD)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .co2_level_i    (sensor_level),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pulse_count_o  (pulse_count_o),
    .mode_now_o     (mode_now_o),
    .reference_now_o(reference_now_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check the word taken at this edge, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(pulse_count_o, mode_now_o, reference_now_o);
    end
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // readings mostly close to the reference and the limits so trend and limit checks flip
  function automatic logic [LEVEL_W-1:0] pick_level();
    int          v;
    int          spread;
    int unsigned roll;
    roll   = $urandom_range(99);
    spread = int'(tracker.trend_margin) + 4;
    if (roll < 40) begin
      v = int'(tracker.ref_level) - spread + int'($urandom_range(2 * spread));
    end else if (roll < 60) begin
      v = int'($urandom_range(tracker.high_limit, tracker.low_limit));
    end else if (roll < 70) begin
      v = int'(tracker.high_limit) - 2 + int'($urandom_range(4));
    end else if (roll < 80) begin
      v = int'(tracker.low_limit) - 2 + int'($urandom_range(4));
    end else if (roll < 92) begin
      v = int'($urandom_range(16'hFFFF));
    end else begin
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 1;
        2:       v = 16'hFFFE;
        default: v = 16'hFFFF;
      endcase
    end
    if (v < 0) v = 0;
    if (v > 16'hFFFF) v = 16'hFFFF;
    return v[LEVEL_W-1:0];
  endfunction

  task automatic send_reading(input logic [LEVEL_W-1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sensor_level <= level;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_reading(level);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_reading(pick_level());
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // also hits the unused index, which must leave every register alone
  task automatic program_regs(input logic [CFG_DATA_W-1:0] high, input logic [CFG_DATA_W-1:0] low,
                              input logic [CFG_DATA_W-1:0] margin);
    write_reg(REG_HIGH_LIMIT, high);
    write_reg(REG_LOW_LIMIT, low);
    write_reg(REG_TREND_MARGIN, margin);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(16'hFFFF)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_words();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [LEVEL_W-1:0] corner_levels[$];
    logic [LEVEL_W-1:0] a;
    logic [LEVEL_W-1:0] b;
    corner_levels = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'hAAAA, 16'h5555,
                      16'h8000, 16'h7FFF, 16'd800, 16'd801, 16'd799, 16'd650,
                      16'd649, 16'd651, 16'd640, 16'd660, 16'hFF00, 16'h00FF};
    tracker = new(SETTLE_PERIOD, TREND_PERIOD);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        2: program_regs(16'hFFFF, 16'h0000, 16'hFFFF);
        3: program_regs(16'h0000, 16'hFFFF, 16'h0000);
        PRESSURE_PHASE: program_regs(HIGH_LIMIT_RST, LOW_LIMIT_RST, TREND_MARGIN_RST);
        default: begin
          a = LEVEL_W'($urandom_range(16'hFFFF));
          b = LEVEL_W'($urandom_range(16'hFFFF));
          // mostly a sane band with low below high, sometimes inverted
          if ($urandom_range(99) < 75 && a < b) begin
            program_regs(b, a, CFG_DATA_W'($urandom_range(16'hFFFF)));
          end else begin
            program_regs(a, b, CFG_DATA_W'($urandom_range(16'hFFFF)));
          end
        end
      endcase

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase

      if (ph == 0) begin
        foreach (corner_levels[i]) send_reading(corner_levels[i]);
      end

      if (ph == PRESSURE_PHASE) begin
        // long receiver hold-off while readings keep coming, so the input backs up
        fork
          begin
            recv_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            recv_hold <= 1'b0;
          end
          send_random(ITEMS_PER_PHASE);
        join
      end else begin
        send_random(ITEMS_PER_PHASE);
      end
      drain_words();
    end

    tracker.report_leftover();
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
